// ===== rtl/core/rvm_pkg.sv =====
// Shared types and codes for the resampling voice mixer.
package rvm_pkg;

	localparam int PHASE_W = 32;
	localparam int LEN_W   = 16;
	localparam int STEP_W  = 24;
	localparam int GAIN_W  = 16;
	localparam int SUM_W   = 33;

	localparam logic [2:0] REQ_LOAD   = 3'd0;
	localparam logic [2:0] REQ_START  = 3'd1;
	localparam logic [2:0] REQ_STOP   = 3'd2;
	localparam logic [2:0] REQ_VOLUME = 3'd3;
	localparam logic [2:0] REQ_STEP   = 3'd4;
	localparam logic [2:0] REQ_MIX    = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_VOICE,
		ST_FETCH,
		ST_ML,
		ST_MR,
		ST_GL,
		ST_GR,
		ST_ACC,
		ST_PHASE,
		ST_WRAP,
		ST_MOD,
		ST_NEXT,
		ST_DONE
	} state_t;

endpackage

// ===== rtl/core/rvm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rvm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/resampling_voice_mixer.sv =====
// Top level of the resampling voice mixer: command decode, voice state and mix sequencer.
//
// Commands arrive as beats on the s_axis channel, the request kind in tuser. Every accepted
// beat yields exactly one result beat on m_axis: the mixed stereo frame for a mix request,
// zeros for other requests, and the playing mask after the request has taken effect.
// A mix request walks the voices in index order with one shared multiplier and one
// byte-wide wave memory port. An idle voice is skipped. An active voice fetches two to
// eight wave bytes, from the frame format, and when a looping voice's phase must be
// reduced, the bit-serial remainder unit reduces it.
// The block takes one request at a time and is not ready while a mix is in progress.
// A finished result sits in an output register, so the next request is accepted while it
// waits; a stall on m_axis holds that beat and blocks only the next result.
// Reset clears all voices to inactive with length one, zero phase, step and gain.
// The wave memory is not cleared; bytes must be loaded before a voice plays them.
// The wave memory size must be a power of two.
module resampling_voice_mixer import rvm_pkg::*; #(
	parameter int VOICES     = 8,
	parameter int WAVE_BYTES = 65536,
	parameter int FRAC_BITS  = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// voice, address, wave_byte, length_frames, stereo, wide_samples, loop, step,
	// volume_left, volume_right
	input  logic [103:0] s_axis_tdata,
	// req_type
	input  logic [2:0]   s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// mix_left, mix_right, playing_mask
	output logic [39:0]  m_axis_tdata
);

	localparam int AW   = $clog2(WAVE_BYTES);
	localparam int VW   = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int IW   = PHASE_W - FRAC_BITS;
	localparam int DW   = LEN_W + FRAC_BITS;
	localparam int CW   = (IW + 1 > LEN_W) ? IW + 1 : LEN_W;
	localparam int SW0  = (AW > IW + 3) ? AW : IW + 3;
	localparam int SW   = (SW0 > LEN_W) ? SW0 : LEN_W;
	localparam int MBW  = (FRAC_BITS > GAIN_W) ? FRAC_BITS : GAIN_W;
	localparam int PRW  = MBW + 19;
	localparam int TW   = FRAC_BITS + 20;
	localparam int RW   = (DW + 1 > SUM_W) ? DW + 1 : SUM_W;
	localparam int XW   = (DW > PHASE_W) ? DW : PHASE_W;
	localparam logic signed [TW-1:0] LERP_BIAS = TW'((64'd1 << FRAC_BITS) - 64'd1);
	localparam logic [5:0] MOD_LAST = 6'(SUM_W - 1);

	logic [2:0]          in_req;
	logic [2:0]          in_voice;
	logic [15:0]         in_address;
	logic [7:0]          in_wave_byte;
	logic [LEN_W-1:0]    in_length;
	logic                in_stereo;
	logic                in_wide;
	logic                in_loop;
	logic [STEP_W-1:0]   in_step;
	logic [GAIN_W-1:0]   in_vol_l;
	logic [GAIN_W-1:0]   in_vol_r;

	assign in_req       = s_axis_tuser;
	assign in_voice     = s_axis_tdata[2:0];
	assign in_address   = s_axis_tdata[18:3];
	assign in_wave_byte = s_axis_tdata[26:19];
	assign in_length    = s_axis_tdata[42:27];
	assign in_stereo    = s_axis_tdata[43];
	assign in_wide      = s_axis_tdata[44];
	assign in_loop      = s_axis_tdata[45];
	assign in_step      = s_axis_tdata[69:46];
	assign in_vol_l     = s_axis_tdata[85:70];
	assign in_vol_r     = s_axis_tdata[101:86];

	state_t state_q, state_d;

	logic                active_q [VOICES];
	logic [PHASE_W-1:0]  phase_q  [VOICES];
	logic [STEP_W-1:0]   step_q   [VOICES];
	logic [15:0]         base_q   [VOICES];
	logic [LEN_W-1:0]    len_q    [VOICES];
	logic [2:0]          fmt_q    [VOICES];
	logic [2*GAIN_W-1:0] gain_q   [VOICES];

	logic [VW-1:0]       k_q;
	logic [AW-1:0]       fa0_q, fa1_q;
	logic                past0_q, past1_q;
	logic [3:0]          rd_cnt_q;
	logic                cap_vld_s1, cap_last_s1;
	logic [2:0]          cap_slot_s1;
	logic [7:0]          buf_q [8];
	logic signed [PRW-1:0] prod_q;
	logic signed [16:0]  lerp_l_q, lerp_r_q;
	logic signed [15:0]  acc_l_q, acc_r_q;
	logic [SUM_W-1:0]    sum_q;
	logic [RW-1:0]       rem_q;
	logic [SUM_W-1:0]    dvd_q;
	logic [5:0]          mod_cnt_q;
	logic                out_vld_q;
	logic [39:0]         out_q;

	logic                in_acc;
	logic                vok;
	logic [VW-1:0]       vsel;
	logic [7:0]          mask;

	logic [PHASE_W-1:0]  cur_ph;
	logic [LEN_W-1:0]    cur_len;
	logic                cur_st, cur_wd, cur_lp;
	logic [1:0]          sh;
	logic [IW-1:0]       idx0;
	logic [IW:0]         idx1x, idx1e;
	logic                past0, past1;
	logic [AW-1:0]       fa0, fa1;
	logic [FRAC_BITS-1:0] frac;
	logic [3:0]          last_cnt;
	logic [2:0]          i3;
	logic                fsel;
	logic [1:0]          bsel;
	logic [AW-1:0]       raddr;
	logic [7:0]          rdata;
	logic signed [16:0]  l0, r0, l1, r1;
	logic [RW-1:0]       dval, sumr, diffr, remsh, rem_n;
	logic                lt_d, diff_lt_d;
	logic signed [15:0]  gain_acc_l, gain_acc_r;

	logic                rd_issue;
	logic signed [17:0]  ma;
	logic [MBW-1:0]      mb;
	logic signed [PRW-1:0] prod_d;
	logic                ph_we;
	logic [PHASE_W-1:0]  ph_wd;
	logic                mod_start;
	logic                out_load;

	function automatic logic signed [16:0] samp(input logic [7:0] lo, input logic [7:0] hi,
			input logic wd);
		logic signed [16:0] n;
		n = $signed({1'b0, lo, 8'd0}) - 17'sd32767;
		return wd ? $signed({hi[7], hi, lo}) : n;
	endfunction

	function automatic logic signed [16:0] lerp(input logic signed [16:0] a,
			input logic signed [PRW-1:0] p);
		logic signed [TW-1:0] t;
		logic signed [TW-1:0] s;
		t = (TW'(a) <<< FRAC_BITS) + TW'(p);
		s = (t < 0) ? t + LERP_BIAS : t;
		s = s >>> FRAC_BITS;
		return s[16:0];
	endfunction

	function automatic logic signed [15:0] gain_add(input logic signed [15:0] acc,
			input logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] b;
		logic signed [18:0] sum;
		b = (p < 0) ? p + PRW'(32767) : p;
		b = b >>> 15;
		sum = 19'(acc) + 19'($signed(b[17:0]));
		if (sum > 19'sd32767) begin
			return 16'sh7fff;
		end
		if (sum < -19'sd32768) begin
			return 16'sh8000;
		end
		return sum[15:0];
	endfunction

	function automatic logic [PHASE_W-1:0] sat_phase(input logic [RW-1:0] x);
		return (|x[RW-1:PHASE_W]) ? '1 : x[PHASE_W-1:0];
	endfunction

	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign vok    = 32'(in_voice) < VOICES;
	assign vsel   = VW'(in_voice);

	always_comb begin
		cur_ph  = phase_q[k_q];
		cur_len = len_q[k_q];
		cur_st  = fmt_q[k_q][0];
		cur_wd  = fmt_q[k_q][1];
		cur_lp  = fmt_q[k_q][2];
		sh      = {1'b0, cur_st} + {1'b0, cur_wd};
		idx0    = cur_ph[PHASE_W-1:FRAC_BITS];
		frac    = cur_ph[FRAC_BITS-1:0];
		idx1x   = {1'b0, idx0} + (IW+1)'(1);
		past0   = CW'(idx0) >= CW'(cur_len);
		past1   = !cur_lp && (CW'(idx1x) >= CW'(cur_len));
		idx1e   = (cur_lp && (CW'(idx1x) == CW'(cur_len))) ? '0 : idx1x;
		fa0     = AW'(SW'(base_q[k_q]) + (SW'(idx0) << sh));
		fa1     = AW'(SW'(base_q[k_q]) + (SW'(idx1e) << sh));
	end

	always_comb begin
		last_cnt = 4'((4'd2 << sh) - 4'd1);
		i3       = rd_cnt_q[2:0];
		fsel     = (i3 >> sh) != 3'd0;
		bsel     = 2'(i3 & 3'((3'd1 << sh) - 3'd1));
		raddr    = (fsel ? fa1_q : fa0_q) + AW'(bsel);
	end

	always_comb begin
		l0 = past0_q ? 17'sd0 : samp(buf_q[0], buf_q[1], cur_wd);
		l1 = past1_q ? 17'sd0 : samp(buf_q[4], buf_q[5], cur_wd);
		r0 = l0;
		r1 = l1;
		if (cur_st) begin
			r0 = past0_q ? 17'sd0 : (cur_wd ? samp(buf_q[2], buf_q[3], 1'b1)
				: samp(buf_q[1], 8'd0, 1'b0));
			r1 = past1_q ? 17'sd0 : (cur_wd ? samp(buf_q[6], buf_q[7], 1'b1)
				: samp(buf_q[5], 8'd0, 1'b0));
		end
	end

	always_comb begin
		dval      = RW'({cur_len, {FRAC_BITS{1'b0}}});
		sumr      = RW'(sum_q);
		diffr     = sumr - dval;
		lt_d      = sumr < dval;
		diff_lt_d = diffr < dval;
		remsh     = {rem_q[RW-2:0], dvd_q[SUM_W-1]};
		rem_n     = (remsh >= dval) ? remsh - dval : remsh;
		gain_acc_l = gain_add(acc_l_q, prod_q);
		gain_acc_r = gain_add(acc_r_q, prod_q);
	end

	always_comb begin
		prod_d = ma * $signed({1'b0, mb});
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					state_d = (in_req == REQ_MIX) ? ST_VOICE : ST_DONE;
				end
			end
			ST_VOICE: state_d = active_q[k_q] ? ST_FETCH : ST_NEXT;
			ST_FETCH: begin
				if (cap_vld_s1 && cap_last_s1) begin
					state_d = ST_ML;
				end
			end
			ST_ML:    state_d = ST_MR;
			ST_MR:    state_d = ST_GL;
			ST_GL:    state_d = ST_GR;
			ST_GR:    state_d = ST_ACC;
			ST_ACC:   state_d = ST_PHASE;
			ST_PHASE: state_d = ST_WRAP;
			ST_WRAP:  state_d = (cur_lp && !lt_d && !diff_lt_d) ? ST_MOD : ST_NEXT;
			ST_MOD: begin
				if (mod_cnt_q == MOD_LAST) begin
					state_d = ST_NEXT;
				end
			end
			ST_NEXT:  state_d = (k_q == VW'(VOICES - 1)) ? ST_DONE : ST_VOICE;
			ST_DONE: begin
				if (!out_vld_q || m_axis_tready) begin
					state_d = ST_IDLE;
				end
			end
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_axis_tready = 1'b0;
		rd_issue      = 1'b0;
		ma            = '0;
		mb            = '0;
		ph_we         = 1'b0;
		ph_wd         = '0;
		mod_start     = 1'b0;
		out_load      = 1'b0;
		case (state_q)
			ST_IDLE:  s_axis_tready = 1'b1;
			ST_FETCH: rd_issue = rd_cnt_q <= last_cnt;
			ST_ML: begin
				ma = 18'(l1) - 18'(l0);
				mb = MBW'(frac);
			end
			ST_MR: begin
				ma = 18'(r1) - 18'(r0);
				mb = MBW'(frac);
			end
			ST_GL: begin
				ma = 18'(lerp_l_q);
				mb = MBW'(gain_q[k_q][GAIN_W-1:0]);
			end
			ST_GR: begin
				ma = 18'(lerp_r_q);
				mb = MBW'(gain_q[k_q][2*GAIN_W-1:GAIN_W]);
			end
			ST_WRAP: begin
				if (!cur_lp || lt_d) begin
					ph_we = 1'b1;
					ph_wd = sat_phase(sumr);
				end else if (diff_lt_d) begin
					ph_we = 1'b1;
					ph_wd = sat_phase(diffr);
				end else begin
					mod_start = 1'b1;
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == MOD_LAST) begin
					ph_we = 1'b1;
					ph_wd = sat_phase(rem_n);
				end
			end
			ST_DONE:  out_load = !out_vld_q || m_axis_tready;
			default:  ;
		endcase
	end

	rvm_ram #(
		.WIDTH(8),
		.DEPTH(WAVE_BYTES)
	) u_wave (
		.clk   (clk),
		.we    (in_acc && (in_req == REQ_LOAD)),
		.waddr (AW'(in_address)),
		.wdata (in_wave_byte),
		.raddr (raddr),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int v = 0; v < VOICES; v++) begin
				active_q[v] <= 1'b0;
				phase_q[v]  <= '0;
				step_q[v]   <= '0;
				base_q[v]   <= '0;
				len_q[v]    <= LEN_W'(1);
				fmt_q[v]    <= '0;
				gain_q[v]   <= '0;
			end
		end else begin
			if (in_acc && vok) begin
				case (in_req)
					REQ_START: begin
						active_q[vsel] <= 1'b1;
						phase_q[vsel]  <= '0;
						base_q[vsel]   <= in_address;
						len_q[vsel]    <= (in_length == '0) ? LEN_W'(1) : in_length;
						fmt_q[vsel]    <= {in_loop, in_wide, in_stereo};
						step_q[vsel]   <= in_step;
						gain_q[vsel]   <= {in_vol_r, in_vol_l};
					end
					REQ_STOP:   active_q[vsel] <= 1'b0;
					REQ_VOLUME: gain_q[vsel] <= {in_vol_r, in_vol_l};
					REQ_STEP:   step_q[vsel] <= in_step;
					default:    ;
				endcase
			end
			if (ph_we) begin
				phase_q[k_q] <= ph_wd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q         <= '0;
			rd_cnt_q    <= '0;
			cap_vld_s1  <= 1'b0;
			mod_cnt_q   <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (in_acc) begin
				k_q <= '0;
			end else if (state_q == ST_NEXT) begin
				k_q <= k_q + VW'(1);
			end
			if (state_q == ST_VOICE) begin
				rd_cnt_q <= '0;
			end else if (rd_issue) begin
				rd_cnt_q <= rd_cnt_q + 4'd1;
			end
			cap_vld_s1 <= rd_issue;
			if (mod_start) begin
				mod_cnt_q <= '0;
			end else if (state_q == ST_MOD) begin
				mod_cnt_q <= mod_cnt_q + 6'd1;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_VOICE) begin
			fa0_q   <= fa0;
			fa1_q   <= fa1;
			past0_q <= past0;
			past1_q <= past1;
		end
		cap_slot_s1 <= {fsel, bsel};
		cap_last_s1 <= rd_cnt_q == last_cnt;
		if (cap_vld_s1) begin
			buf_q[cap_slot_s1] <= rdata;
		end
		prod_q <= prod_d;
		if (state_q == ST_MR) begin
			lerp_l_q <= lerp(l0, prod_q);
		end
		if (state_q == ST_GL) begin
			lerp_r_q <= lerp(r0, prod_q);
		end
		if (in_acc) begin
			acc_l_q <= '0;
			acc_r_q <= '0;
		end else begin
			if (state_q == ST_GR) begin
				acc_l_q <= gain_acc_l;
			end
			if (state_q == ST_ACC) begin
				acc_r_q <= gain_acc_r;
			end
		end
		if (state_q == ST_PHASE) begin
			sum_q <= SUM_W'(cur_ph) + SUM_W'(step_q[k_q]);
		end
		if (mod_start) begin
			rem_q <= '0;
			dvd_q <= sum_q;
		end else if (state_q == ST_MOD) begin
			rem_q <= rem_n;
			dvd_q <= {dvd_q[SUM_W-2:0], 1'b0};
		end
		if (out_load) begin
			out_q <= {mask, acc_r_q, acc_l_q};
		end
	end

	for (genvar g = 0; g < 8; g++) begin : g_mask
		if (g < VOICES) begin : g_on
			assign mask[g] = active_q[g] &&
				(XW'(phase_q[g]) < XW'({len_q[g], {FRAC_BITS{1'b0}}}));
		end else begin : g_off
			assign mask[g] = 1'b0;
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata  = out_q;

endmodule

// ===== rtl/core/rvm_chk.sv =====
// Port-level checker for the resampling voice mixer, bound to its top level.
module rvm_chk (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic [103:0] s_axis_tdata,
	input logic [2:0]   s_axis_tuser,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [39:0]  m_axis_tdata
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request accepted on consecutive cycles");

	a_handshake_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tready, m_axis_tvalid}))
		else $error("handshake output unknown after reset");

endmodule

bind resampling_voice_mixer rvm_chk u_rvm_chk (.*);

// ===== tb/resampling_voice_mixer_tb.sv =====
// Self-checking testbench for the resampling voice mixer with a built-in mixer prediction.
module resampling_voice_mixer_tb;
	import rvm_pkg::*;

	typedef struct {
		logic [2:0]  req;
		logic [2:0]  voice;
		logic [15:0] address;
		logic [7:0]  wave_byte;
		logic [15:0] length_frames;
		logic        stereo;
		logic        wide;
		logic        loop;
		logic [23:0] step;
		logic [15:0] vol_l;
		logic [15:0] vol_r;
	} voice_cmd_t;

	typedef struct {
		logic [15:0] left;
		logic [15:0] right;
		logic [7:0]  mask;
	} mix_beat_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [103:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;

	resampling_voice_mixer u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	byte unsigned wave_mem [65536];
	bit           wave_written [65536];
	bit           v_active [8];
	bit [31:0]    v_phase [8];
	bit [23:0]    v_step [8];
	bit [15:0]    v_base [8];
	bit [16:0]    v_len [8];
	bit [2:0]     v_fmt [8];
	bit [15:0]    v_gain_l [8];
	bit [15:0]    v_gain_r [8];

	voice_cmd_t   pending_cmds [$];
	mix_beat_t    expected_mix [$];
	int           errors;
	int           cycle_count;

	function automatic int sat16(longint x);
		if (x > 32767)
			return 32767;
		if (x < -32768)
			return -32768;
		return int'(x);
	endfunction

	function automatic void read_frame(int k, longint idx, output int l, output int r);
		longint a;
		int bpf;
		if (v_fmt[k][2] && idx >= v_len[k])
			idx = idx % v_len[k];
		if (idx >= v_len[k]) begin
			l = 0;
			r = 0;
			return;
		end
		bpf = (v_fmt[k][0] ? 2 : 1) * (v_fmt[k][1] ? 2 : 1);
		a = longint'(v_base[k]) + idx * bpf;
		if (v_fmt[k][1]) begin
			l = int'($signed({wave_mem[(a + 1) & 16'hFFFF], wave_mem[a & 16'hFFFF]}));
			r = v_fmt[k][0] ? int'($signed({wave_mem[(a + 3) & 16'hFFFF],
				wave_mem[(a + 2) & 16'hFFFF]})) : l;
		end else begin
			l = int'(wave_mem[a & 16'hFFFF]) * 256 - 32767;
			r = v_fmt[k][0] ? int'(wave_mem[(a + 1) & 16'hFFFF]) * 256 - 32767 : l;
		end
	endfunction

	function automatic void frame_bytes(int k, longint idx, ref int unsigned addrs[$]);
		longint a;
		int bpf;
		if (v_fmt[k][2] && idx >= v_len[k])
			idx = idx % v_len[k];
		if (idx >= v_len[k])
			return;
		bpf = (v_fmt[k][0] ? 2 : 1) * (v_fmt[k][1] ? 2 : 1);
		a = longint'(v_base[k]) + idx * bpf;
		for (int i = 0; i < bpf; i++)
			addrs.push_back(int'((a + i) & 16'hFFFF));
	endfunction

	function automatic int interp(int a, int b, longint frac);
		longint t;
		t = longint'(a) * 65536 + longint'(b - a) * frac;
		return int'(t / 65536);
	endfunction

	function automatic int scale(int s, bit [15:0] g);
		return int'((longint'(s) * longint'(g)) / 32768);
	endfunction

	function automatic mix_beat_t mixer_apply(voice_cmd_t c);
		mix_beat_t res;
		int accl, accr, l0, r0, l1, r1;
		longint nxt, idx, frac;
		accl = 0;
		accr = 0;
		case (c.req)
			REQ_LOAD: begin
				wave_mem[c.address] = c.wave_byte;
				wave_written[c.address] = 1;
			end
			REQ_START: begin
				v_active[c.voice] = 1;
				v_phase[c.voice] = 0;
				v_base[c.voice] = c.address;
				v_len[c.voice] = (c.length_frames == 0) ? 17'd1 : {1'b0, c.length_frames};
				v_fmt[c.voice] = {c.loop, c.wide, c.stereo};
				v_step[c.voice] = c.step;
				v_gain_l[c.voice] = c.vol_l;
				v_gain_r[c.voice] = c.vol_r;
			end
			REQ_STOP: v_active[c.voice] = 0;
			REQ_VOLUME: begin
				v_gain_l[c.voice] = c.vol_l;
				v_gain_r[c.voice] = c.vol_r;
			end
			REQ_STEP: v_step[c.voice] = c.step;
			REQ_MIX: begin
				for (int k = 0; k < 8; k++) begin
					if (!v_active[k])
						continue;
					idx = v_phase[k] >> 16;
					frac = v_phase[k] & 32'hFFFF;
					read_frame(k, idx, l0, r0);
					read_frame(k, idx + 1, l1, r1);
					accl = sat16(longint'(accl) + scale(interp(l0, l1, frac), v_gain_l[k]));
					accr = sat16(longint'(accr) + scale(interp(r0, r1, frac), v_gain_r[k]));
					nxt = longint'(v_phase[k]) + longint'(v_step[k]);
					if (v_fmt[k][2])
						nxt = nxt % (longint'(v_len[k]) << 16);
					if (nxt > 64'hFFFFFFFF)
						nxt = 64'hFFFFFFFF;
					v_phase[k] = nxt[31:0];
				end
			end
			default: ;
		endcase
		res.left = accl[15:0];
		res.right = accr[15:0];
		res.mask = '0;
		for (int k = 0; k < 8; k++)
			res.mask[k] = v_active[k] && (longint'(v_phase[k]) < (longint'(v_len[k]) << 16));
		return res;
	endfunction

	// Before a mix, every byte the active voices will read is loaded if it never was.
	function automatic void queue_cmd(voice_cmd_t c);
		int unsigned addrs[$];
		voice_cmd_t ld;
		if (c.req == REQ_MIX) begin
			for (int k = 0; k < 8; k++) begin
				if (!v_active[k])
					continue;
				frame_bytes(k, v_phase[k] >> 16, addrs);
				frame_bytes(k, (v_phase[k] >> 16) + 1, addrs);
			end
			foreach (addrs[i]) begin
				if (!wave_written[addrs[i]]) begin
					ld = c;
					ld.req = REQ_LOAD;
					ld.address = addrs[i][15:0];
					ld.wave_byte = 8'($urandom);
					pending_cmds.push_back(ld);
					expected_mix.push_back(mixer_apply(ld));
				end
			end
		end
		pending_cmds.push_back(c);
		expected_mix.push_back(mixer_apply(c));
	endfunction

	function automatic voice_cmd_t random_cmd(bit spare_voice0);
		voice_cmd_t c;
		int pick;
		c.voice = 3'($urandom);
		c.address = 16'($urandom);
		c.wave_byte = 8'($urandom);
		c.length_frames = 16'($urandom);
		c.stereo = 1'($urandom);
		c.wide = 1'($urandom);
		c.loop = 1'($urandom);
		c.step = 24'($urandom);
		c.vol_l = 16'($urandom);
		c.vol_r = 16'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 15)
			c.req = REQ_LOAD;
		else if (pick < 30)
			c.req = REQ_START;
		else if (pick < 36)
			c.req = REQ_STOP;
		else if (pick < 43)
			c.req = REQ_VOLUME;
		else if (pick < 50)
			c.req = REQ_STEP;
		else if (pick < 97)
			c.req = REQ_MIX;
		else
			c.req = 3'($urandom_range(6, 7));
		if ($urandom_range(0, 19) != 0)
			c.length_frames = 16'($urandom_range(0, 12));
		if ($urandom_range(0, 3) != 0)
			c.step = 24'($urandom_range(0, 24'h3FFFF));
		else if ($urandom_range(0, 3) == 0)
			c.step = ($urandom_range(0, 1) != 0) ? 24'hFFFFFF : 24'h0;
		if ($urandom_range(0, 4) == 0)
			c.vol_l = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0;
		if ($urandom_range(0, 4) == 0)
			c.vol_r = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h8000;
		if (spare_voice0 && c.voice == 0 && c.req inside {REQ_START, REQ_STOP, REQ_STEP})
			c.voice = 3'd1;
		return c;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Command driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata <= '0;
			s_axis_tuser <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (pending_cmds.size() != 0 &&
					((cycle_count > 3000 && cycle_count < 15000) || $urandom_range(0, 99) >= 12)) begin
				voice_cmd_t c;
				c = pending_cmds.pop_front();
				s_axis_tvalid <= 1;
				s_axis_tuser <= c.req;
				s_axis_tdata <= {2'b0, c.vol_r, c.vol_l, c.step, c.loop, c.wide, c.stereo,
					c.length_frames, c.wave_byte, c.address, c.voice};
			end else begin
				s_axis_tvalid <= 0;
			end
		end
	end

	// Result monitor and back-pressure.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 0;
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			m_axis_tready <= (cycle_count > 30000 && cycle_count < 45000) ||
				$urandom_range(0, 99) >= 12;
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_mix.size() == 0) begin
					$display("%0t: unexpected beat, actual %h", $time, m_axis_tdata);
					errors++;
				end else begin
					mix_beat_t e;
					e = expected_mix.pop_front();
					if (m_axis_tdata[15:0] !== e.left) begin
						$display("%0t: mix_left expected %h actual %h", $time, e.left,
							m_axis_tdata[15:0]);
						errors++;
					end
					if (m_axis_tdata[31:16] !== e.right) begin
						$display("%0t: mix_right expected %h actual %h", $time, e.right,
							m_axis_tdata[31:16]);
						errors++;
					end
					if (m_axis_tdata[39:32] !== e.mask) begin
						$display("%0t: playing_mask expected %h actual %h", $time, e.mask,
							m_axis_tdata[39:32]);
						errors++;
					end
				end
			end
		end
	end

	initial begin
		voice_cmd_t c;
		for (int k = 0; k < 8; k++)
			v_len[k] = 1;
		arst_n = 0;

		c = '{REQ_START, 3'd0, 16'h0100, 8'h00, 16'd3, 1'b0, 1'b0, 1'b0, 24'hFFFFFF,
			16'hFFFF, 16'hFFFF};
		queue_cmd(c);
		queue_cmd('{REQ_START, 3'd7, 16'hFFFE, 8'h00, 16'd4, 1'b1, 1'b1, 1'b1, 24'h018000,
			16'h8000, 16'h4000});
		queue_cmd('{REQ_START, 3'd1, 16'h0200, 8'h00, 16'd0, 1'b1, 1'b0, 1'b0, 24'h000000,
			16'hFFFF, 16'h0000});
		queue_cmd('{REQ_START, 3'd2, 16'h0300, 8'h00, 16'hFFFF, 1'b0, 1'b1, 1'b0, 24'h008000,
			16'h7FFF, 16'hFFFF});
		queue_cmd('{REQ_MIX, 3'd0, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0});
		queue_cmd('{REQ_LOAD, 3'd5, 16'h0000, 8'hFF, 16'd0, 1'b1, 1'b1, 1'b1, 24'hFFFFFF,
			16'hFFFF, 16'hFFFF});
		queue_cmd('{REQ_LOAD, 3'd5, 16'hFFFF, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0});
		queue_cmd('{REQ_VOLUME, 3'd7, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'hFFFF,
			16'hFFFF});
		queue_cmd('{REQ_STEP, 3'd2, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'hFFFFFF, 16'h0,
			16'h0});
		for (int i = 0; i < 4; i++)
			queue_cmd('{REQ_MIX, 3'd0, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0});
		queue_cmd('{3'd6, 3'd3, 16'h1234, 8'h55, 16'd9, 1'b1, 1'b1, 1'b1, 24'h1, 16'h1, 16'h1});
		queue_cmd('{3'd7, 3'd4, 16'h4321, 8'hAA, 16'd9, 1'b0, 1'b1, 1'b0, 24'h2, 16'h2, 16'h2});
		queue_cmd('{REQ_STOP, 3'd2, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0});
		queue_cmd('{REQ_START, 3'd7, 16'hFFFD, 8'h00, 16'd2, 1'b0, 1'b0, 1'b1, 24'h01FFFF,
			16'h0000, 16'hFFFF});
		queue_cmd('{REQ_MIX, 3'd0, 16'h0, 8'h00, 16'd0, 1'b0, 1'b0, 1'b0, 24'h0, 16'h0, 16'h0});

		// Voice 0 is not restarted, stopped or given a new step for a while, so its phase runs into saturation.
		while (pending_cmds.size() < 1250)
			queue_cmd(random_cmd(pending_cmds.size() < 700));

		repeat (6) @(posedge clk);
		arst_n <= 1;

		wait (pending_cmds.size() == 0 && expected_mix.size() == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("resampling_voice_mixer_tb: PASS");
		else
			$display("resampling_voice_mixer_tb: FAIL");
		$finish;
	end

	initial begin
		#50000000;
		$display("resampling_voice_mixer_tb: FAIL");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/rvm_pkg.sv
rtl/core/rvm_ram.sv
rtl/core/resampling_voice_mixer.sv
rtl/core/rvm_chk.sv
tb/resampling_voice_mixer_tb.sv
